/* hdl/teletext_enhancement_triplet_decoder_assert.svh */
// Assertion macros shared by the triplet decoder files.
`ifndef TELETEXT_ENHANCEMENT_TRIPLET_DECODER_ASSERT_SVH
`define TELETEXT_ENHANCEMENT_TRIPLET_DECODER_ASSERT_SVH

// same-cycle implication
`define TETD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TETD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tetd_pkg.sv */
// Types, constants and character tables of the enhancement triplet decoder.
`timescale 1ns / 1ps
package tetd_pkg;

  localparam int TRIPLET_W = 18;
  localparam int ROW_W     = 5;
  localparam int COL_W     = 6;
  localparam int CHAR_W    = 8;

  localparam int PAGE_WIDTH  = 40;
  localparam int PAGE_HEIGHT = 25;

  localparam logic [10:0] FILLER      = 11'd2047;
  localparam logic [5:0]  ROW_ADR_MIN = 6'd40;
  localparam logic [5:0]  ROW_ADR_TOP = 6'd63;
  localparam logic [4:0]  ROW_LAST    = 5'd24;
  localparam logic [6:0]  G2_FIRST    = 7'd32;

  localparam logic [4:0] MODE_SET_ROW     = 5'd1;
  localparam logic [4:0] MODE_SET_ROW_ALT = 5'd4;
  localparam logic [4:0] MODE_ROW_HOME    = 5'd7;
  localparam logic [4:0] MODE_G2          = 5'd15;
  localparam logic [4:0] MODE_MARK_FIRST  = 5'd16;

  typedef struct packed {
    logic [TRIPLET_W-1:0] triplet;
    logic                 page_start;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;
    logic [CHAR_W-1:0] char_code;
  } result_t;

  localparam logic [7:0] G2_LATIN1 [96] = '{
    8'h20,8'hA1,8'hA2,8'hA3,8'h24,8'hA5,8'h23,8'hA7,8'hA4,8'h27,8'h22,8'hAB,8'h20,8'h20,8'h20,8'h20,
    8'hB0,8'hB1,8'hB2,8'hB3,8'hD7,8'hB5,8'hB6,8'hB7,8'hF7,8'h27,8'h22,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF,
    8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'h20,8'h20,8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'h22,8'h20,8'h20,
    8'h5F,8'hB9,8'hAE,8'hA9,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'hC6,8'hD0,8'hAA,8'h48,8'h20,8'h49,8'h4C,8'h4C,8'hD8,8'h20,8'hBA,8'hDE,8'h54,8'h4E,8'h6E,
    8'h4B,8'hE6,8'h64,8'hF0,8'h68,8'h69,8'h69,8'h6C,8'h6C,8'hF8,8'h20,8'hDF,8'hFE,8'h74,8'h6E,8'h7F
  };

  localparam logic [7:0] G2_LATIN2 [96] = '{
    8'h20,8'h69,8'h63,8'h4C,8'h24,8'h59,8'h23,8'hA7,8'hA4,8'h27,8'h22,8'h3C,8'h20,8'h20,8'h20,8'h20,
    8'hB0,8'h20,8'h20,8'h20,8'hD7,8'h75,8'h20,8'h20,8'hF7,8'h27,8'h22,8'h3E,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h60,8'hB4,8'h5E,8'h7E,8'h20,8'hA2,8'hFF,8'hA8,8'h2E,8'hB0,8'hB8,8'h5F,8'hBD,8'hB2,8'hB7,
    8'h2D,8'h20,8'h52,8'h43,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h20,8'h20,8'hD0,8'h61,8'h48,8'h20,8'h69,8'h4C,8'hA3,8'h4F,8'h20,8'h6F,8'h70,8'h54,8'h4E,8'h6E,
    8'h4B,8'h20,8'hF0,8'h64,8'h68,8'h69,8'h69,8'h6C,8'hB3,8'h6F,8'h20,8'hDF,8'h70,8'h74,8'h6E,8'h7F
  };

  // diacritical mark composition: returns {latin1 code, latin2 code}
  function automatic logic [15:0] mark_pair(logic [3:0] mark, logic [6:0] data);
    logic [15:0] p;
    case ({mark, data})
      {4'd0, 7'h23}: p = 16'hA424;
      {4'd1, 7'h20}: p = 16'h6060;
      {4'd1, 7'h61}: p = 16'hE061;
      {4'd1, 7'h65}: p = 16'hE865;
      {4'd1, 7'h69}: p = 16'hEC69;
      {4'd1, 7'h6F}: p = 16'hF26F;
      {4'd1, 7'h75}: p = 16'hF975;
      {4'd1, 7'h41}: p = 16'hC041;
      {4'd1, 7'h45}: p = 16'hC845;
      {4'd1, 7'h49}: p = 16'hCC49;
      {4'd1, 7'h4F}: p = 16'hD24F;
      {4'd1, 7'h55}: p = 16'hD955;
      {4'd2, 7'h20}: p = 16'h2727;
      {4'd2, 7'h61}: p = 16'hE1E1;
      {4'd2, 7'h63}: p = 16'h63E6;
      {4'd2, 7'h65}: p = 16'hE9E9;
      {4'd2, 7'h69}: p = 16'hEDED;
      {4'd2, 7'h6C}: p = 16'h6CE5;
      {4'd2, 7'h6E}: p = 16'h6EF1;
      {4'd2, 7'h6F}: p = 16'hF3F3;
      {4'd2, 7'h72}: p = 16'h72E0;
      {4'd2, 7'h73}: p = 16'h73B6;
      {4'd2, 7'h75}: p = 16'hFAFA;
      {4'd2, 7'h79}: p = 16'hFDFD;
      {4'd2, 7'h7A}: p = 16'h7ABC;
      {4'd2, 7'h41}: p = 16'hC1C1;
      {4'd2, 7'h43}: p = 16'h43C6;
      {4'd2, 7'h45}: p = 16'hC9C9;
      {4'd2, 7'h49}: p = 16'hCDCD;
      {4'd2, 7'h4C}: p = 16'h4CC5;
      {4'd2, 7'h4E}: p = 16'h4ED1;
      {4'd2, 7'h4F}: p = 16'hD3D3;
      {4'd2, 7'h52}: p = 16'h52C0;
      {4'd2, 7'h53}: p = 16'h53A6;
      {4'd2, 7'h55}: p = 16'hDADA;
      {4'd2, 7'h59}: p = 16'hDDDD;
      {4'd2, 7'h5A}: p = 16'h5AAC;
      {4'd3, 7'h20}: p = 16'h5E5E;
      {4'd3, 7'h61}: p = 16'hE2E2;
      {4'd3, 7'h65}: p = 16'hEA65;
      {4'd3, 7'h69}: p = 16'hEEEE;
      {4'd3, 7'h6F}: p = 16'hF4F4;
      {4'd3, 7'h75}: p = 16'hFB75;
      {4'd3, 7'h41}: p = 16'hC2C2;
      {4'd3, 7'h45}: p = 16'hCA45;
      {4'd3, 7'h49}: p = 16'hCECE;
      {4'd3, 7'h4F}: p = 16'hD4D4;
      {4'd3, 7'h55}: p = 16'hDB55;
      {4'd4, 7'h20}: p = 16'h7E7E;
      {4'd4, 7'h61}: p = 16'hE361;
      {4'd4, 7'h6E}: p = 16'hF16E;
      {4'd4, 7'h6F}: p = 16'hF56F;
      {4'd4, 7'h41}: p = 16'hC341;
      {4'd4, 7'h4E}: p = 16'hD14E;
      {4'd4, 7'h4F}: p = 16'hD54F;
      {4'd6, 7'h61}: p = 16'h61E3;
      {4'd6, 7'h41}: p = 16'h41C3;
      {4'd7, 7'h7A}: p = 16'h7ABF;
      {4'd7, 7'h5A}: p = 16'h5AAF;
      {4'd8, 7'h61}: p = 16'hE4E4;
      {4'd8, 7'h65}: p = 16'hEBEB;
      {4'd8, 7'h69}: p = 16'hEF69;
      {4'd8, 7'h6F}: p = 16'hF6F6;
      {4'd8, 7'h75}: p = 16'hFCFC;
      {4'd8, 7'h41}: p = 16'hC4C4;
      {4'd8, 7'h45}: p = 16'hCBCB;
      {4'd8, 7'h49}: p = 16'hCF49;
      {4'd8, 7'h4F}: p = 16'hD6D6;
      {4'd8, 7'h55}: p = 16'hDCDC;
      {4'd10, 7'h20}: p = 16'hB0B0;
      {4'd10, 7'h61}: p = 16'hE561;
      {4'd10, 7'h75}: p = 16'h75F9;
      {4'd10, 7'h41}: p = 16'hC541;
      {4'd10, 7'h55}: p = 16'h55D9;
      {4'd11, 7'h63}: p = 16'hE7E7;
      {4'd11, 7'h73}: p = 16'h73BA;
      {4'd11, 7'h74}: p = 16'h74FE;
      {4'd11, 7'h43}: p = 16'hC7C7;
      {4'd11, 7'h53}: p = 16'h53AA;
      {4'd11, 7'h54}: p = 16'h54DE;
      {4'd12, 7'h20}: p = 16'h5F5F;
      {4'd13, 7'h20}: p = 16'h2222;
      {4'd13, 7'h6F}: p = 16'h6FF5;
      {4'd13, 7'h75}: p = 16'h75FB;
      {4'd13, 7'h4F}: p = 16'h4FD5;
      {4'd13, 7'h55}: p = 16'h55DB;
      {4'd14, 7'h61}: p = 16'h61B1;
      {4'd14, 7'h65}: p = 16'h65EA;
      {4'd14, 7'h41}: p = 16'h41A1;
      {4'd14, 7'h45}: p = 16'h45CA;
      {4'd15, 7'h63}: p = 16'h63E8;
      {4'd15, 7'h64}: p = 16'h64EF;
      {4'd15, 7'h65}: p = 16'h65EC;
      {4'd15, 7'h6C}: p = 16'h6CB5;
      {4'd15, 7'h6E}: p = 16'h6EF2;
      {4'd15, 7'h72}: p = 16'h72F8;
      {4'd15, 7'h73}: p = 16'h73B9;
      {4'd15, 7'h74}: p = 16'h74BB;
      {4'd15, 7'h7A}: p = 16'h7ABE;
      {4'd15, 7'h43}: p = 16'h43C8;
      {4'd15, 7'h44}: p = 16'h44CF;
      {4'd15, 7'h45}: p = 16'h45CC;
      {4'd15, 7'h4C}: p = 16'h4CA5;
      {4'd15, 7'h4E}: p = 16'h4ED2;
      {4'd15, 7'h52}: p = 16'h52D8;
      {4'd15, 7'h53}: p = 16'h53A9;
      {4'd15, 7'h54}: p = 16'h54AB;
      {4'd15, 7'h5A}: p = 16'h5AAE;
      default:        p = {1'b0, data, 1'b0, data};
    endcase
    return p;
  endfunction

endpackage

/* hdl/tetd_in_if.sv */
// Triplet input channel.
`timescale 1ns / 1ps
interface tetd_in_if;
  logic                           valid;
  logic                           ready;
  logic [tetd_pkg::TRIPLET_W-1:0] triplet;
  logic                           page_start;

  modport source (output valid, triplet, page_start, input ready);
  modport sink (input valid, triplet, page_start, output ready);
endinterface

/* hdl/tetd_out_if.sv */
// Character write output channel.
`timescale 1ns / 1ps
interface tetd_out_if;
  logic                        valid;
  logic                        ready;
  logic [tetd_pkg::ROW_W-1:0]  row;
  logic [tetd_pkg::COL_W-1:0]  column;
  logic [tetd_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, row, column, char_code, input ready);
  modport sink (input valid, row, column, char_code, output ready);
endinterface

/* hdl/teletext_enhancement_triplet_decoder.sv */
// Top level of the enhancement triplet decoder.
//
//   channel    direction  handshake     payload
//   triplets   in         valid/ready   triplet[17:0], page_start
//   chars      out        valid/ready   row[4:0], column[5:0], char_code[7:0]
//   cfg        in         cfg_wr_en     cfg_wr_data (charset_latin1)
//
// One triplet per cycle unless a character meets a stalled result register;
// a character passes from the input register into the result register.
// Reset clears the active row, the stage valid flags and selects Latin-1.
// A stalled result register holds a pending character; input ready then drops.
`timescale 1ns / 1ps
`include "teletext_enhancement_triplet_decoder_assert.svh"
module teletext_enhancement_triplet_decoder (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  tetd_in_if.sink   triplets,
  tetd_out_if.source chars
);
  import tetd_pkg::*;

  logic     charset_latin1;
  logic     valid;
  in_item_t item;
  result_t  res;
  logic     take;
  logic     free;

  assign take           = valid && (!res.hit || free);
  assign triplets.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      charset_latin1 <= 1'b1;
    end else if (cfg_wr_en) begin
      charset_latin1 <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (triplets.ready) begin
      valid <= triplets.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (triplets.ready && triplets.valid) begin
      item.triplet    <= triplets.triplet;
      item.page_start <= triplets.page_start;
    end
  end

  tetd_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .item           (item),
    .charset_latin1 (charset_latin1),
    .res            (res)
  );

  tetd_out_stage u_out (
    .clk   (clk),
    .rst   (rst),
    .load  (take && res.hit),
    .res   (res),
    .free  (free),
    .chars (chars)
  );

  `TETD_ASSERT_NOW(a_load_free, clk, rst, take && res.hit, free,
    "result loaded over a pending transaction")
  `TETD_ASSERT_NOW(a_col_range, clk, rst, chars.valid, 32'(chars.column) < PAGE_WIDTH,
    "column outside page")
  `TETD_ASSERT_NEXT(a_stall_holds, clk, rst, valid && !take, valid,
    "pending triplet dropped")
endmodule

/* hdl/tetd_decode.sv */
// Triplet decode and active row register.
`timescale 1ns / 1ps
`include "teletext_enhancement_triplet_decoder_assert.svh"
module tetd_decode (
  input  logic               clk,
  input  logic               rst,
  input  logic               take,
  input  tetd_pkg::in_item_t item,
  input  logic               charset_latin1,
  output tetd_pkg::result_t  res
);
  import tetd_pkg::*;

  logic [ROW_W-1:0] active_row;
  logic [ROW_W-1:0] active_row_next;
  logic [ROW_W-1:0] base_row;
  logic [ROW_W-1:0] row_adr;
  logic [5:0]       adr;
  logic [4:0]       mode;
  logic [6:0]       data;
  logic [6:0]       g2_idx;
  logic [15:0]      pair;
  logic             filler;
  logic             row_func;
  logic             g2_hit;

  assign adr      = item.triplet[5:0];
  assign mode     = item.triplet[10:6];
  assign data     = item.triplet[17:11];
  assign filler   = (item.triplet[10:0] == FILLER);
  assign row_func = (adr >= ROW_ADR_MIN);
  assign base_row = item.page_start ? '0 : active_row;
  assign g2_idx   = data - G2_FIRST;
  assign pair     = mark_pair(mode[3:0], data);
  assign g2_hit   = (mode == MODE_G2) && (data >= G2_FIRST);

  always_comb begin
    row_adr = 5'(adr - ROW_ADR_MIN);
    if (row_adr == '0) begin
      row_adr = ROW_LAST;
    end
  end

  always_comb begin
    active_row_next = base_row;
    if (!filler && row_func) begin
      if (mode inside {MODE_SET_ROW, MODE_SET_ROW_ALT}) begin
        active_row_next = row_adr;
      end else if (mode == MODE_ROW_HOME && adr == ROW_ADR_TOP) begin
        active_row_next = '0;
      end
    end
  end

  always_comb begin
    res.hit = !filler && !row_func && (32'(adr) < PAGE_WIDTH)
              && (32'(base_row) < PAGE_HEIGHT)
              && (g2_hit || mode >= MODE_MARK_FIRST);
    res.row    = base_row;
    res.column = adr;
    if (mode == MODE_G2) begin
      res.char_code = charset_latin1 ? G2_LATIN1[g2_idx] : G2_LATIN2[g2_idx];
    end else begin
      res.char_code = charset_latin1 ? pair[15:8] : pair[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_row <= '0;
    end else if (take) begin
      active_row <= active_row_next;
    end
  end

  `TETD_ASSERT_NOW(a_row_in_page, clk, rst, 1'b1, active_row <= ROW_LAST,
    "active row beyond last page row")
  `TETD_ASSERT_NEXT(a_page_start_home, clk, rst, take && item.page_start && filler,
    active_row == '0, "page start did not clear active row")
  `TETD_ASSERT_NOW(a_hit_column_only, clk, rst, res.hit, !row_func && !filler,
    "result from row function or filler")
endmodule

/* hdl/tetd_out_stage.sv */
// Output result register.
`timescale 1ns / 1ps
module tetd_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tetd_pkg::result_t res,
  output logic              free,
  tetd_out_if.source        chars
);
  import tetd_pkg::*;

  logic              valid;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  column;
  logic [CHAR_W-1:0] char_code;

  assign free = !valid || chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (chars.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row       <= res.row;
      column    <= res.column;
      char_code <= res.char_code;
    end
  end

  assign chars.valid     = valid;
  assign chars.row       = row;
  assign chars.column    = column;
  assign chars.char_code = char_code;
endmodule

/* sim/teletext_enhancement_triplet_decoder_tb.sv */
// Self-checking testbench of the enhancement triplet decoder: predicts each character write.
`timescale 1ns / 1ps

typedef struct {
  logic [tetd_pkg::ROW_W-1:0]  row;
  logic [tetd_pkg::COL_W-1:0]  column;
  logic [tetd_pkg::CHAR_W-1:0] char_code;
} char_write_t;

function automatic logic [7:0] g2_char(int k, bit latin1);
  logic [767:0] tbl;
  if (latin1) begin
    tbl = {128'h20A1A2A3_24A523A7_A42722AB_20202020,
           128'hB0B1B2B3_D7B5B6B7_F72722BB_BCBDBEBF,
           128'h2060B45E_7E202020_A82EB0B8_5F222020,
           128'h5FB9AEA9_20202020_20202020_20202020,
           128'h20C6D0AA_4820494C_4CD820BA_DE544E6E,
           128'h4BE664F0_6869696C_6CF820DF_FE746E7F};
  end else begin
    tbl = {128'h2069634C_245923A7_A427223C_20202020,
           128'hB0202020_D7752020_F727223E_20202020,
           128'h2060B45E_7E20A2FF_A82EB0B8_5FBDB2B7,
           128'h2D205243_20202020_20202020_20202020,
           128'h2020D061_4820694C_A34F206F_70544E6E,
           128'h4B20F064_6869696C_B36F20DF_70746E7F};
  end
  return tbl[8*(95-k) +: 8];
endfunction

// base letters of a mark, with their composed codes right-aligned, first letter highest
function automatic void mark_table(input logic [3:0] mark, output string letters,
                                   output logic [199:0] l1, output logic [199:0] l2);
  letters = "";
  l1 = '0;
  l2 = '0;
  case (mark)
    4'd0: begin
      letters = "#"; l1 = 200'hA4; l2 = 200'h24;
    end
    4'd1: begin
      letters = " aeiouAEIOU";
      l1 = 200'h60E0E8ECF2F9C0C8CCD2D9;
      l2 = 200'h606165696F754145494F55;
    end
    4'd2: begin
      letters = " aceilnorsuyzACEILNORSUYZ";
      l1 = 200'h27E163E9_ED6C6EF3_7273FAFD_7AC143C9_CD4C4ED3_5253DADD_5A;
      l2 = 200'h27E1E6E9_EDE5F1F3_E0B6FAFD_BCC1C6C9_CDC5D1D3_C0A6DADD_AC;
    end
    4'd3: begin
      letters = " aeiouAEIOU";
      l1 = 200'h5EE2EAEEF4FBC2CACED4DB;
      l2 = 200'h5EE265EEF475C245CED455;
    end
    4'd4: begin
      letters = " anoANO"; l1 = 200'h7EE3F1F5C3D1D5; l2 = 200'h7E616E6F414E4F;
    end
    4'd6: begin
      letters = "aA"; l1 = 200'h6141; l2 = 200'hE3C3;
    end
    4'd7: begin
      letters = "zZ"; l1 = 200'h7A5A; l2 = 200'hBFAF;
    end
    4'd8: begin
      letters = "aeiouAEIOU";
      l1 = 200'hE4EBEFF6FCC4CBCFD6DC;
      l2 = 200'hE4EB69F6FCC4CB49D6DC;
    end
    4'd10: begin
      letters = " auAU"; l1 = 200'hB0E575C555; l2 = 200'hB061F941D9;
    end
    4'd11: begin
      letters = "cstCST"; l1 = 200'hE77374C75354; l2 = 200'hE7BAFEC7AADE;
    end
    4'd12: begin
      letters = " "; l1 = 200'h5F; l2 = 200'h5F;
    end
    4'd13: begin
      letters = " ouOU"; l1 = 200'h226F754F55; l2 = 200'h22F5FBD5DB;
    end
    4'd14: begin
      letters = "aeAE"; l1 = 200'h61654145; l2 = 200'hB1EAA1CA;
    end
    4'd15: begin
      letters = "cdelnrstzCDELNRSTZ";
      l1 = 200'h6364656C_6E727374_7A434445_4C4E5253_545A;
      l2 = 200'hE8EFECB5_F2F8B9BB_BEC8CFCC_A5D2D8A9_ABAE;
    end
    default: ;
  endcase
endfunction

function automatic logic [7:0] marked_char(logic [3:0] mark, logic [6:0] data, bit latin1);
  string letters;
  logic [199:0] l1;
  logic [199:0] l2;
  int n;
  mark_table(mark, letters, l1, l2);
  n = letters.len();
  for (int i = 0; i < n; i++) begin
    if (letters[i] == {1'b0, data})
      return latin1 ? l1[8*(n-1-i) +: 8] : l2[8*(n-1-i) +: 8];
  end
  return {1'b0, data};
endfunction

class char_write_board;
  bit          latin1;
  logic [4:0]  cur_row;
  char_write_t due_q[$];
  int          errors;

  function new();
    latin1  = 1'b1;
    cur_row = '0;
    errors  = 0;
  endfunction

  function void note_triplet(logic [17:0] trip, logic page_start);
    logic [5:0]  adr;
    logic [4:0]  mode;
    logic [6:0]  data;
    logic [5:0]  r;
    char_write_t w;
    adr  = trip[5:0];
    mode = trip[10:6];
    data = trip[17:11];
    if (page_start)
      cur_row = '0;
    if (trip[10:0] == tetd_pkg::FILLER)
      return;
    if (adr >= tetd_pkg::ROW_ADR_MIN) begin
      r = adr - tetd_pkg::ROW_ADR_MIN;
      if (r == 0)
        r = {1'b0, tetd_pkg::ROW_LAST};
      if (mode == tetd_pkg::MODE_SET_ROW || mode == tetd_pkg::MODE_SET_ROW_ALT)
        cur_row = r[4:0];
      else if (mode == tetd_pkg::MODE_ROW_HOME && adr == tetd_pkg::ROW_ADR_TOP)
        cur_row = '0;
      return;
    end
    if (adr >= tetd_pkg::PAGE_WIDTH || cur_row >= tetd_pkg::PAGE_HEIGHT)
      return;
    if (mode == tetd_pkg::MODE_G2) begin
      if (data < tetd_pkg::G2_FIRST)
        return;
      w.char_code = g2_char(int'(data - tetd_pkg::G2_FIRST), latin1);
    end else if (mode >= tetd_pkg::MODE_MARK_FIRST) begin
      w.char_code = marked_char(mode[3:0], data, latin1);
    end else begin
      return;
    end
    w.row    = cur_row;
    w.column = adr;
    due_q.push_back(w);
  endfunction

  function void check_char(logic [4:0] row, logic [5:0] column, logic [7:0] char_code);
    char_write_t w;
    if (due_q.size() == 0) begin
      $error("unexpected write: row %0d column %0d char_code %h", row, column, char_code);
      errors++;
      return;
    end
    w = due_q.pop_front();
    if (row !== w.row) begin
      $error("row: expected %0d, actual %0d", w.row, row);
      errors++;
    end
    if (column !== w.column) begin
      $error("column: expected %0d, actual %0d", w.column, column);
      errors++;
    end
    if (char_code !== w.char_code) begin
      $error("char_code: expected %h, actual %h", w.char_code, char_code);
      errors++;
    end
  endfunction

  function int pending();
    return due_q.size();
  endfunction
endclass

module teletext_enhancement_triplet_decoder_tb;
  import tetd_pkg::*;

  localparam logic [4:0] MODE_PLAIN     = 5'd0;
  localparam logic [4:0] MODE_ROW_OTHER = 5'd2;
  localparam logic [4:0] MODE_COL_OTHER = 5'd14;
  localparam int         RANDOM_ITEMS   = 250;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;
  bit   quiet;

  char_write_board board;

  tetd_in_if  triplets_if ();
  tetd_out_if chars_if ();

  teletext_enhancement_triplet_decoder u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .triplets    (triplets_if),
    .chars       (chars_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk) begin
    chars_if.ready <= quiet || ($urandom_range(0, 99) >= 13);
  end

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready)
      board.check_char(chars_if.row, chars_if.column, chars_if.char_code);
  end

  function automatic logic [17:0] pack_triplet(logic [5:0] adr, logic [4:0] mode,
                                               logic [6:0] data);
    return {data, mode, adr};
  endfunction

  function automatic logic [4:0] mark_mode(logic [3:0] mark);
    return MODE_MARK_FIRST + {1'b0, mark};
  endfunction

  task automatic send_triplet(logic [17:0] trip, logic page_start);
    while (!quiet && $urandom_range(0, 99) < 13) begin
      triplets_if.valid <= 1'b0;
      @(negedge clk);
    end
    triplets_if.valid      <= 1'b1;
    triplets_if.triplet    <= trip;
    triplets_if.page_start <= page_start;
    @(posedge clk);
    while (!triplets_if.ready)
      @(posedge clk);
    board.note_triplet(trip, page_start);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    triplets_if.valid <= 1'b0;
    while (board.pending() != 0)
      @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_charset(bit latin1);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= latin1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board.latin1 = latin1;
    @(negedge clk);
  endtask

  task automatic random_triplet(output logic [17:0] trip, output logic page_start);
    int          pick;
    int          sel;
    logic [4:0]  mode;
    logic [6:0]  data;
    string       letters;
    logic [199:0] l1;
    logic [199:0] l2;
    pick       = $urandom_range(0, 99);
    page_start = ($urandom_range(0, 99) < 6);
    if (pick < 8) begin
      trip       = 18'($urandom());
      page_start = 1'($urandom_range(0, 1));
    end else if (pick < 12) begin
      trip = {7'($urandom_range(0, 127)), FILLER};
    end else if (pick < 32) begin
      sel = $urandom_range(0, 99);
      if (sel < 40)
        mode = MODE_SET_ROW;
      else if (sel < 70)
        mode = MODE_SET_ROW_ALT;
      else if (sel < 85)
        mode = MODE_ROW_HOME;
      else
        mode = 5'($urandom_range(0, 31));
      trip = pack_triplet(6'($urandom_range(40, 63)), mode, 7'($urandom_range(0, 127)));
    end else if (pick < 52) begin
      trip = pack_triplet(6'($urandom_range(0, 39)), MODE_G2, 7'($urandom_range(0, 127)));
    end else begin
      mode = 5'($urandom_range(16, 31));
      mark_table(mode[3:0], letters, l1, l2);
      if (letters.len() > 0 && $urandom_range(0, 99) < 60)
        data = 7'(letters[$urandom_range(0, letters.len() - 1)]);
      else
        data = 7'($urandom_range(0, 127));
      trip = pack_triplet(6'($urandom_range(0, 39)), mode, data);
    end
  endtask

  initial begin
    logic [17:0] trip;
    logic        page_start;
    int          sent;
    board                  = new();
    quiet                  = 1'b0;
    rst                    = 1'b1;
    cfg_wr_en              = 1'b0;
    cfg_wr_data            = 1'b0;
    triplets_if.valid      = 1'b0;
    triplets_if.triplet    = '0;
    triplets_if.page_start = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_triplet(18'h3FFFF, 1'b1);
    send_triplet(pack_triplet(6'd0, MODE_G2, 7'd32), 1'b0);
    send_triplet(pack_triplet(6'd39, MODE_G2, 7'd127), 1'b0);
    send_triplet(pack_triplet(6'd1, MODE_G2, 7'd31), 1'b0);
    send_triplet(pack_triplet(6'd40, MODE_SET_ROW, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd2, mark_mode(4'd0), 7'h23), 1'b0);
    send_triplet(pack_triplet(6'd63, MODE_SET_ROW_ALT, 7'd5), 1'b0);
    send_triplet(pack_triplet(6'd3, mark_mode(4'd2), 7'h63), 1'b0);
    send_triplet(pack_triplet(6'd50, MODE_ROW_OTHER, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd4, mark_mode(4'd5), 7'h61), 1'b0);
    send_triplet(pack_triplet(6'd63, MODE_ROW_HOME, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd5, mark_mode(4'd9), 7'h20), 1'b0);
    send_triplet(pack_triplet(6'd41, MODE_SET_ROW, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd45, MODE_ROW_HOME, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd6, mark_mode(4'd15), 7'h5A), 1'b0);
    send_triplet(pack_triplet(6'd7, mark_mode(4'd15), 7'h7F), 1'b0);
    send_triplet(pack_triplet(6'd8, MODE_PLAIN, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd9, MODE_COL_OTHER, 7'h40), 1'b0);
    send_triplet(pack_triplet(6'd10, mark_mode(4'd1), 7'h61), 1'b1);
    send_triplet(pack_triplet(6'd0, MODE_PLAIN, 7'd0), 1'b0);
    send_triplet(pack_triplet(6'd39, mark_mode(4'd15), 7'd127), 1'b0);
    send_triplet(pack_triplet(6'd12, mark_mode(4'd4), 7'h6F), 1'b0);
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      write_charset(phase[0]);
      quiet = (phase == 2);
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
        random_triplet(trip, page_start);
        send_triplet(trip, page_start);
        if (trip[10:0] != FILLER)
          sent++;
      end
      wait_idle();
    end
    quiet = 1'b0;

    if (board.errors == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/tetd_pkg.sv
hdl/tetd_in_if.sv
hdl/tetd_out_if.sv
hdl/tetd_decode.sv
hdl/tetd_out_stage.sv
hdl/teletext_enhancement_triplet_decoder.sv
sim/teletext_enhancement_triplet_decoder_tb.sv
